// ===== rtl/assert_macros.svh =====
// assertion helpers included by midpoint_line_rasterizer.sv
// each check is sampled on the rising clock edge and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every sampled edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/mlr_pkg.sv =====
`default_nettype none

package mlr_pkg;

    // command codes carried in s_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam int unsigned CW = 12;  // coordinate width
    localparam int unsigned YW = 14;  // flipped y width
    localparam int unsigned HW = 13;  // window height width
    localparam int unsigned DW = 16;  // decision variable width
    localparam int unsigned SW = 15;  // step width

    // octant cases after ordering by x
    typedef enum logic [1:0] {
        OCT_SHALLOW_UP   = 2'd0,  // major x, y rises (incl. horizontal)
        OCT_STEEP_UP     = 2'd1,  // major y rising, x rises
        OCT_STEEP_DOWN   = 2'd2,  // major y falling, x rises
        OCT_SHALLOW_DOWN = 2'd3   // major x, y falls (incl. slope -1)
    } octant_t;

    // line state produced by endpoint setup
    typedef struct packed {
        octant_t               octant;
        logic [CW-1:0]         major_pos;
        logic [CW-1:0]         major_end;
        logic [CW-1:0]         minor_pos;
        logic signed [DW-1:0]  decision;
        logic signed [SW-1:0]  step_same;
        logic signed [SW-1:0]  step_diag;
    } line_setup_t;

endpackage

`default_nettype wire

// ===== rtl/mlr_setup.sv =====
`default_nettype none

module mlr_setup
    import mlr_pkg::*;
(
    input  wire logic [CW-1:0] x_a,
    input  wire logic [CW-1:0] y_a,
    input  wire logic [CW-1:0] x_b,
    input  wire logic [CW-1:0] y_b,
    output line_setup_t        setup
);

    logic                 swap;
    logic [CW-1:0]        x0, y0, x1, y1;
    logic [CW-1:0]        dx;
    logic signed [CW:0]   dx_s;
    logic signed [CW:0]   dy;
    logic signed [CW:0]   dy_neg;
    logic [CW-1:0]        dmaj, dmin;

    // order endpoints so drawing runs left to right
    assign swap = (x_b < x_a);
    assign x0   = swap ? x_b : x_a;
    assign y0   = swap ? y_b : y_a;
    assign x1   = swap ? x_a : x_b;
    assign y1   = swap ? y_a : y_b;

    assign dx     = x1 - x0;
    assign dx_s   = $signed({1'b0, dx});
    assign dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});
    assign dy_neg = -dy;

    // classify into one of four octant cases
    always_comb begin
        setup = '0;
        dmaj  = dx;
        dmin  = dx;
        priority if (!dy[CW] && (dy <= dx_s)) begin
            setup.octant    = OCT_SHALLOW_UP;
            setup.major_pos = x0;
            setup.major_end = x1;
            setup.minor_pos = y0;
            dmaj            = dx;
            dmin            = dy[CW-1:0];
        end else if (dy > dx_s) begin
            setup.octant    = OCT_STEEP_UP;
            setup.major_pos = y0;
            setup.major_end = y1;
            setup.minor_pos = x0;
            dmaj            = dy[CW-1:0];
            dmin            = dx;
        end else if (dy_neg > dx_s) begin
            setup.octant    = OCT_STEEP_DOWN;
            setup.major_pos = y0;
            setup.major_end = y1;
            setup.minor_pos = x0;
            dmaj            = dy_neg[CW-1:0];
            dmin            = dx;
        end else begin
            setup.octant    = OCT_SHALLOW_DOWN;
            setup.major_pos = x0;
            setup.major_end = x1;
            setup.minor_pos = y0;
            dmaj            = dx;
            dmin            = dy_neg[CW-1:0];
        end
        // doubled midpoint test and its two increments
        setup.decision  = $signed({{(DW-CW){1'b0}}, dmaj})
                        - $signed({{(DW-CW-1){1'b0}}, dmin, 1'b0});
        setup.step_same = $signed({SW{1'b0}})
                        - $signed({{(SW-CW-1){1'b0}}, dmin, 1'b0});
        setup.step_diag = $signed({{(SW-CW-1){1'b0}}, dmaj, 1'b0})
                        - $signed({{(SW-CW-1){1'b0}}, dmin, 1'b0});
    end

endmodule

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer, all octants.
//
// Input stream (s_*): s_tuser = 0 loads two endpoints from s_tdata and returns
// nothing; s_tuser = 1 requests the next pixel of the loaded line. A request
// while no line is active returns nothing. A load while a line is active drops
// the old line. Output stream (m_*): one transfer per pixel, m_tlast on the
// final pixel; pixel y is given as window_height minus y, 14-bit two's complement.
// Config channel (cfg_*): writes window_height, always ready, meant while idle.
//
// A pixel appears on m_* in the cycle after its request transfer.
// Throughput: one item per cycle while the output register is free; each pixel
// step is a single add on the decision register plus the endpoint compare, done
// between state and the output register; loads are accepted at the same rate.
// Stall: the output register frees when m_tready is high, so s_tready follows
// m_tready when a pixel is pending; no item is lost under back pressure.
// Reset (aresetn low, synchronous): no line active, output empty,
// window_height returns to 512.

`default_nettype none

`include "assert_macros.svh"

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // input stream
    input  wire logic          s_tvalid,
    output      logic          s_tready,
    input  wire logic [47:0]   s_tdata,   // x_start, y_start, x_end, y_end (12 bits each)
    input  wire logic [0:0]    s_tuser,   // cmd
    // result stream
    output      logic          m_tvalid,
    input  wire logic          m_tready,
    output      logic [31:0]   m_tdata,   // pixel_x[11:0], pixel_y[25:12], zero pad
    output      logic          m_tlast,   // last_pixel
    // configuration
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    input  wire logic [HW-1:0] cfg_data   // window_height
);

    localparam logic [CW-1:0] CoordMask =
        (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);
    localparam logic [HW-1:0] HeightReset = HW'(512);

    line_setup_t          setup;
    logic                 s_fire;
    logic                 pix_req;
    logic                 at_end;
    logic [CW-1:0]        cur_x, cur_y;

    logic                 busy_reg, busy_next;
    octant_t              octant_reg, octant_next;
    logic [CW-1:0]        major_pos_reg, major_pos_next;
    logic [CW-1:0]        major_end_reg, major_end_next;
    logic [CW-1:0]        minor_pos_reg, minor_pos_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic signed [SW-1:0] step_same_reg, step_same_next;
    logic signed [SW-1:0] step_diag_reg, step_diag_next;
    logic [HW-1:0]        height_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        out_x_reg, out_x_next;
    logic [YW-1:0]        out_y_reg, out_y_next;
    logic                 out_last_reg, out_last_next;

    // endpoint setup for load commands
    mlr_setup u_setup (
        .x_a   (s_tdata[11:0]  & CoordMask),
        .y_a   (s_tdata[23:12] & CoordMask),
        .x_b   (s_tdata[35:24] & CoordMask),
        .y_b   (s_tdata[47:36] & CoordMask),
        .setup (setup)
    );

    // handshake: take an item whenever the output register is free this cycle
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign pix_req   = s_fire && (s_tuser[0] == CMD_PIXEL);
    assign cfg_ready = 1'b1;

    // current pixel on the display axes
    assign at_end = (major_pos_reg == major_end_reg);
    assign cur_x  = ((octant_reg == OCT_STEEP_UP) || (octant_reg == OCT_STEEP_DOWN))
                  ? minor_pos_reg : major_pos_reg;
    assign cur_y  = ((octant_reg == OCT_STEEP_UP) || (octant_reg == OCT_STEEP_DOWN))
                  ? major_pos_reg : minor_pos_reg;

    // line state update
    always_comb begin
        busy_next      = busy_reg;
        octant_next    = octant_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        minor_pos_next = minor_pos_reg;
        decision_next  = decision_reg;
        step_same_next = step_same_reg;
        step_diag_next = step_diag_reg;
        if (s_fire && (s_tuser[0] == CMD_LOAD)) begin
            busy_next      = 1'b1;
            octant_next    = setup.octant;
            major_pos_next = setup.major_pos;
            major_end_next = setup.major_end;
            minor_pos_next = setup.minor_pos;
            decision_next  = setup.decision;
            step_same_next = setup.step_same;
            step_diag_next = setup.step_diag;
        end else if (pix_req && busy_reg) begin
            if (at_end) begin
                busy_next = 1'b0;
            end else begin
                major_pos_next = (octant_reg == OCT_STEEP_DOWN)
                               ? major_pos_reg - CW'(1) : major_pos_reg + CW'(1);
                if (decision_reg[DW-1]) begin
                    minor_pos_next = (octant_reg == OCT_SHALLOW_DOWN)
                                   ? minor_pos_reg - CW'(1) : minor_pos_reg + CW'(1);
                    decision_next  = decision_reg + DW'(step_diag_reg);
                end else begin
                    decision_next  = decision_reg + DW'(step_same_reg);
                end
            end
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        if (s_fire) begin
            out_valid_next = pix_req && busy_reg;
            out_x_next     = cur_x;
            out_y_next     = {1'b0, height_reg} - {{(YW-CW){1'b0}}, cur_y};
            out_last_next  = at_end;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            octant_reg    <= OCT_SHALLOW_UP;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            minor_pos_reg <= '0;
            decision_reg  <= '0;
            step_same_reg <= '0;
            step_diag_reg <= '0;
            out_valid_reg <= 1'b0;
            height_reg    <= HeightReset;
        end else begin
            busy_reg      <= busy_next;
            octant_reg    <= octant_next;
            major_pos_reg <= major_pos_next;
            major_end_reg <= major_end_next;
            minor_pos_reg <= minor_pos_next;
            decision_reg  <= decision_next;
            step_same_reg <= step_same_next;
            step_diag_reg <= step_diag_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                height_reg <= cfg_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32-CW-YW){1'b0}}, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

    // major position never passes the end point
    `ASSERT_NEVER(a_rise_overrun, aclk, aresetn,
        busy_reg && (octant_reg != OCT_STEEP_DOWN) && (major_pos_reg > major_end_reg))
    `ASSERT_NEVER(a_fall_overrun, aclk, aresetn,
        busy_reg && (octant_reg == OCT_STEEP_DOWN) && (major_pos_reg < major_end_reg))
    // a request on an active line yields a pixel next cycle
    `ASSERT_PROP(a_pixel_out, aclk, aresetn,
        (pix_req && busy_reg) |=> m_tvalid)
    // the final pixel ends the line
    `ASSERT_PROP(a_last_ends, aclk, aresetn,
        (pix_req && busy_reg && at_end) |=> (!busy_reg && m_tlast))

endmodule

`default_nettype wire

// ===== tb/sv/tb_midpoint_line_rasterizer.sv =====
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer;
    import mlr_pkg::*;

    localparam int  PHASE_ITEMS = 292;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_LIMIT = 20000;

    // one expected pixel of the line being drawn
    typedef struct packed {
        logic [11:0] px;
        logic [13:0] py;
        logic        last;
    } pixel_t;

    // line walker: follows the midpoint recurrence and queues the pixels it yields
    class line_scoreboard;
        logic [12:0]        height = 13'd512;
        bit                 active = 1'b0;
        octant_t            oct = OCT_SHALLOW_UP;
        logic [12:0]        maj_pos = '0;
        logic [12:0]        maj_end = '0;
        logic [12:0]        min_pos = '0;
        logic signed [15:0] dvar = '0;
        logic signed [14:0] inc_same = '0;
        logic signed [14:0] inc_diag = '0;
        pixel_t             expected_q[$];
        int                 errors = 0;

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string msg);
            if (errors < 50)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // order by x, pick the octant case, and set up the decision terms
        function void load_line(logic [47:0] data);
            int xa, ya, xb, yb, tmp, dx, dy, dmaj, dmin;
            xa = data[11:0];
            ya = data[23:12];
            xb = data[35:24];
            yb = data[47:36];
            if (xb < xa) begin
                tmp = xa; xa = xb; xb = tmp;
                tmp = ya; ya = yb; yb = tmp;
            end
            dx = xb - xa;
            dy = yb - ya;
            if (dy >= 0 && dy <= dx) begin
                oct = OCT_SHALLOW_UP;
                maj_pos = 13'(xa); maj_end = 13'(xb); min_pos = 13'(ya);
                dmaj = dx; dmin = dy;
            end else if (dy > dx) begin
                oct = OCT_STEEP_UP;
                maj_pos = 13'(ya); maj_end = 13'(yb); min_pos = 13'(xa);
                dmaj = dy; dmin = dx;
            end else if (-dy > dx) begin
                oct = OCT_STEEP_DOWN;
                maj_pos = 13'(ya); maj_end = 13'(yb); min_pos = 13'(xa);
                dmaj = -dy; dmin = dx;
            end else begin
                // shallow falling, slope -1 lands here too
                oct = OCT_SHALLOW_DOWN;
                maj_pos = 13'(xa); maj_end = 13'(xb); min_pos = 13'(ya);
                dmaj = dx; dmin = -dy;
            end
            dvar     = 16'(dmaj - 2 * dmin);
            inc_same = 15'(-2 * dmin);
            inc_diag = 15'(2 * (dmaj - dmin));
            active   = 1'b1;
        endfunction

        // accepted input transfer: load a line or emit the next pixel
        function void note_item(logic cmd, logic [47:0] data);
            pixel_t      p;
            logic [12:0] yv;
            if (cmd == CMD_LOAD) begin
                load_line(data);
                return;
            end
            if (!active)
                return;
            if (oct == OCT_STEEP_UP || oct == OCT_STEEP_DOWN) begin
                p.px = min_pos[11:0];
                yv   = maj_pos;
            end else begin
                p.px = maj_pos[11:0];
                yv   = min_pos;
            end
            p.py   = 14'(height) - 14'(yv);
            p.last = (maj_pos == maj_end);
            expected_q.push_back(p);
            if (p.last) begin
                active = 1'b0;
            end else begin
                maj_pos = (oct == OCT_STEEP_DOWN) ? maj_pos - 13'd1 : maj_pos + 13'd1;
                // a zero decision keeps the minor coordinate
                if (dvar < 0) begin
                    min_pos = (oct == OCT_SHALLOW_DOWN) ? min_pos - 13'd1 : min_pos + 13'd1;
                    dvar = dvar + inc_diag;
                end else begin
                    dvar = dvar + inc_same;
                end
            end
        endfunction

        // accepted output transfer against the oldest expected pixel
        task check_pixel(input logic [11:0] px, input logic [13:0] py, input logic last);
            pixel_t e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                          px, $signed(py), last));
                return;
            end
            e = expected_q.pop_front();
            if (px !== e.px)
                report_mismatch($sformatf("pixel_x got %0d want %0d", px, e.px));
            if (py !== e.py)
                report_mismatch($sformatf("pixel_y got %0d want %0d",
                                          $signed(py), $signed(e.py)));
            if (last !== e.last)
                report_mismatch($sformatf("last_pixel got %0b want %0b", last, e.last));
        endtask

        task flag_leftovers();
            while (expected_q.size() != 0) begin
                report_mismatch($sformatf("pixel x=%0d never arrived", expected_q[0].px));
                void'(expected_q.pop_front());
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // x_start, y_start, x_end, y_end (12 bits each)
    logic [0:0]  s_tuser = '0;    // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // pixel_x[11:0], pixel_y[25:12], zero pad
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;

    line_scoreboard sb = new();
    bit             steady = 1'b0;
    int             stall_left = 0;
    int             items_sent = 0;
    int             cycle_count = 0;

    midpoint_line_rasterizer #(
        .COORD_BITS(12)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // result side back pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            stall_left = pick_gap();
        end
    end

    // observe every transfer at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata[11:0], m_tdata[25:12], m_tlast);
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser[0], s_tdata);
            if (cfg_valid && cfg_ready)
                sb.height = cfg_data;
        end
    end

    // one input transfer; entered and left at a falling edge, tvalid stays up
    task automatic send_item(input logic cmd, input logic [47:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_load(input int x0, input int y0, input int x1, input int y1);
        send_item(CMD_LOAD, {12'(y1), 12'(x1), 12'(y0), 12'(x0)});
    endtask

    // pixel requests carry junk endpoints, which the block must ignore
    task automatic send_requests(input int n);
        repeat (n) send_item(CMD_PIXEL, 48'({$urandom(), $urandom()}));
    endtask

    // drop tvalid and let every pending pixel come out
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_height(input logic [12:0] h);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = h;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // mostly whole lines with random geometry, some cut short, some stray requests
    task automatic run_random(input int budget);
        int target, sel, span, x0, y0, x1, y1, adx, ady, npix, nreq;
        target = items_sent + budget;
        while (items_sent < target) begin
            if ($urandom_range(0, 24) == 0)
                steady = !steady;
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                send_requests($urandom_range(1, 3));
                continue;
            end
            span = (sel < 85) ? 12 : (sel < 97) ? 150 : 4095;
            x0 = $urandom_range(0, 4095);
            y0 = $urandom_range(0, 4095);
            x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                y1 = y0;
            end else if (sel < 20) begin
                x1 = x0;
            end else if (sel < 28) begin
                // exact diagonal, either direction
                adx = (x1 > x0) ? x1 - x0 : x0 - x1;
                ady = $urandom_range(0, 1) ? y0 + adx : y0 - adx;
                if (ady >= 0 && ady <= 4095)
                    y1 = ady;
            end
            adx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady  = (y1 > y0) ? y1 - y0 : y0 - y1;
            npix = ((adx > ady) ? adx : ady) + 1;
            if (span == 4095)
                nreq = $urandom_range(1, 150);
            else if ($urandom_range(0, 3) != 0)
                nreq = npix + $urandom_range(0, 2);
            else
                nreq = $urandom_range(0, npix);
            send_load(x0, y0, x1, y1);
            send_requests(nreq);
        end
    endtask

    initial begin
        logic [12:0] h;
        int          waited;

        // reset
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: single point then a request while idle
        send_load(5, 5, 5, 5);
        send_requests(2);
        // full-range diagonal, cut short by the next load
        send_load(0, 0, 4095, 4095);
        send_requests(2);
        // leftward horizontal at the far corner
        send_load(4095, 4095, 4093, 4095);
        send_requests(3);
        // downward vertical
        send_load(0, 2, 0, 0);
        send_requests(3);
        // slope -1, given right to left
        send_load(2, 0, 0, 2);
        send_requests(3);
        // steep rising with a zero decision on the first step
        send_load(0, 0, 1, 2);
        send_requests(3);

        // random phases, each under its own window height
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: h = 13'd1;
                1: h = 13'd4096;
                2: h = 13'd8191;
                3: h = 13'd0;
                4: h = 13'($urandom_range(0, 8191));
                default: h = 13'($urandom_range(1, 4096));
            endcase
            write_height(h);
            run_random(PHASE_ITEMS);
        end

        // drain and check
        s_tvalid = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (8) @(negedge aclk);
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mlr_pkg.sv
rtl/mlr_setup.sv
rtl/midpoint_line_rasterizer.sv
tb/sv/tb_midpoint_line_rasterizer.sv
